[hdl/phs_pkg.sv]
// Package for the position hint scanner: scan modes, result record and helpers.
// Used by phs_scan, phs_out_reg and position_hint_scanner; depends on nothing.
`timescale 1ns / 1ps

package phs_pkg;

   // Longest comment that is still scanned, in characters
   localparam int MAX_LEN = 4096;
   // Character counter saturates at MAX_LEN + 1
   localparam int CNT_W = $clog2(MAX_LEN + 2);
   // Headroom so that the counter can be zero-extended to any index field
   localparam int EXT_W = CNT_W + 14;

   localparam int BEGIN_W = 12;
   localparam int END_W   = 13;
   localparam int MAG_W   = 31;
   localparam int ACC_W   = MAG_W + 4;

   localparam logic [ACC_W-1:0] INT_LIMIT = ACC_W'(32'h7FFF_FFFF);

   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [3:0] {
      MODE_SEARCH,
      MODE_NEED_SPACE,
      MODE_SKIP1,
      MODE_SIGN1,
      MODE_DIG1,
      MODE_SKIP2,
      MODE_SIGN2,
      MODE_DIG2,
      MODE_DONE
   } mode_type;

   typedef struct packed {
      logic               found;
      logic [31:0]        x;
      logic [31:0]        y;
      logic [BEGIN_W-1:0] ints_begin;
      logic [END_W-1:0]   ints_end;
      logic               too_long;
   } result_type;

   // Expected character of the marker at the given progress
   function automatic logic [7:0] marker_char(input logic [1:0] prog);
      logic [7:0] c;
      unique case (prog)
         2'd0:    c = CH_AT;
         2'd1:    c = CH_P;
         2'd2:    c = CH_O;
         default: c = CH_S;
      endcase
      return c;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   // Two's complement value from sign and magnitude
   function automatic logic [31:0] signed_value(input logic [MAG_W-1:0] mag,
                                                input logic neg);
      logic [31:0] m;
      m = {1'b0, mag};
      return neg ? (32'd0 - m) : m;
   endfunction

endpackage

[hdl/phs_scan.sv]
// Scan engine: marker search, number parsing and the result of each comment.
// Depends on phs_pkg.
`timescale 1ns / 1ps

module phs_scan
   import phs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,      // one character is consumed this cycle
   input  logic [7:0] ch,
   input  logic       last,
   output result_type result     // valid in the cycle of a last character
);

   mode_type               mode_ff, mode_in;
   logic [1:0]             prog_ff, prog_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [MAG_W-1:0]       mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [31:0]            first_ff, first_in;
   logic [BEGIN_W-1:0]     begin_ff, begin_in;
   logic [31:0]            held_x_ff, held_x_in;
   logic [31:0]            held_y_ff, held_y_in;
   logic [BEGIN_W-1:0]     held_begin_ff, held_begin_in;
   logic [END_W-1:0]       held_end_ff, held_end_in;

   logic                   over;
   logic [EXT_W-1:0]       idx_ext;
   logic [EXT_W-1:0]       idx_next_ext;
   logic [3:0]             digit;
   logic [ACC_W-1:0]       acc;
   logic                   acc_ok;
   logic [MAG_W-1:0]       digit_mag;
   logic                   fail;

   assign idx_ext      = EXT_W'(count_ff);
   assign idx_next_ext = idx_ext + EXT_W'(1);
   assign digit        = 4'(ch - CH_ZERO);
   assign digit_mag    = MAG_W'(digit);
   // magnitude * 10 + digit
   assign acc    = {mag_ff, 3'b000} + {2'b00, mag_ff, 1'b0} + ACC_W'(digit);
   assign acc_ok = (acc <= INT_LIMIT);

   // Saturating character count and overlong detection
   always_comb begin
      count_in = (count_ff <= CNT_W'(MAX_LEN)) ? count_ff + CNT_W'(1) : count_ff;
      over     = (count_in > CNT_W'(MAX_LEN));
   end

   // Next state for one character
   always_comb begin
      mode_in       = mode_ff;
      prog_in       = prog_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      first_in      = first_ff;
      begin_in      = begin_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      held_begin_in = held_begin_ff;
      held_end_in   = held_end_ff;
      fail          = 1'b0;

      if (!over) begin
         unique case (mode_ff) inside
            MODE_SEARCH: begin
               if (ch == marker_char(prog_ff)) begin
                  if (prog_ff == 2'd3) begin
                     prog_in = 2'd0;
                     mode_in = MODE_NEED_SPACE;
                  end else begin
                     prog_in = prog_ff + 2'd1;
                  end
               end else begin
                  prog_in = {1'b0, ch == CH_AT};
               end
            end
            MODE_NEED_SPACE: begin
               if (is_blank(ch)) mode_in = MODE_SKIP1;
               else fail = 1'b1;
            end
            MODE_SKIP1: begin
               if (!is_blank(ch)) begin
                  begin_in = idx_ext[BEGIN_W-1:0];
                  neg_in   = (ch == CH_MINUS);
                  if (is_sign(ch)) begin
                     mag_in  = '0;
                     mode_in = MODE_SIGN1;
                  end else if (is_digit(ch)) begin
                     mag_in  = digit_mag;
                     mode_in = MODE_DIG1;
                  end else begin
                     fail = 1'b1;
                  end
               end
            end
            MODE_SIGN1, MODE_SIGN2: begin
               // magnitude is zero here, so the first digit always fits
               if (is_digit(ch)) begin
                  mag_in  = digit_mag;
                  mode_in = (mode_ff == MODE_SIGN1) ? MODE_DIG1 : MODE_DIG2;
               end else begin
                  fail = 1'b1;
               end
            end
            MODE_DIG1: begin
               if (is_digit(ch)) begin
                  if (acc_ok) mag_in = acc[MAG_W-1:0];
                  else fail = 1'b1;
               end else if (is_blank(ch)) begin
                  first_in = signed_value(mag_ff, neg_ff);
                  mode_in  = MODE_SKIP2;
               end else if (is_sign(ch)) begin
                  first_in = signed_value(mag_ff, neg_ff);
                  neg_in   = (ch == CH_MINUS);
                  mag_in   = '0;
                  mode_in  = MODE_SIGN2;
               end else begin
                  fail = 1'b1;
               end
            end
            MODE_SKIP2: begin
               if (!is_blank(ch)) begin
                  neg_in = (ch == CH_MINUS);
                  if (is_sign(ch)) begin
                     mag_in  = '0;
                     mode_in = MODE_SIGN2;
                  end else if (is_digit(ch)) begin
                     mag_in  = digit_mag;
                     mode_in = MODE_DIG2;
                  end else begin
                     fail = 1'b1;
                  end
               end
            end
            MODE_DIG2: begin
               if (is_digit(ch)) begin
                  if (acc_ok) mag_in = acc[MAG_W-1:0];
                  else fail = 1'b1;
               end else if (is_blank(ch)) begin
                  held_x_in     = first_ff;
                  held_y_in     = signed_value(mag_ff, neg_ff);
                  held_begin_in = begin_ff;
                  held_end_in   = idx_ext[END_W-1:0];
                  mode_in       = MODE_DONE;
               end else begin
                  fail = 1'b1;
               end
            end
            MODE_DONE: begin
               // first hint is kept, later characters are only counted
            end
            default: begin
               mode_in = MODE_SEARCH;
            end
         endcase

         // Failed candidate: the character is looked at again as a marker start
         if (fail) begin
            mode_in = MODE_SEARCH;
            prog_in = {1'b0, ch == CH_AT};
         end
      end
   end

   // Result of the comment, taken on its last character
   always_comb begin
      result = '0;
      if (over) begin
         result.too_long = 1'b1;
      end else if (mode_in == MODE_DIG2) begin
         // comment ends inside the second integer
         result.found      = 1'b1;
         result.x          = first_in;
         result.y          = signed_value(mag_in, neg_in);
         result.ints_begin = begin_in;
         result.ints_end   = idx_next_ext[END_W-1:0];
      end else if (mode_in == MODE_DONE) begin
         result.found      = 1'b1;
         result.x          = held_x_in;
         result.y          = held_y_in;
         result.ints_begin = held_begin_in;
         result.ints_end   = held_end_in;
      end
   end

   // Control state; a last character returns the scanner to its start
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SEARCH;
         prog_ff  <= 2'd0;
         count_ff <= '0;
      end else if (step) begin
         if (last) begin
            mode_ff  <= MODE_SEARCH;
            prog_ff  <= 2'd0;
            count_ff <= '0;
         end else begin
            mode_ff  <= mode_in;
            prog_ff  <= prog_in;
            count_ff <= count_in;
         end
      end
   end

   // Number and hint payload
   always_ff @(posedge clock) begin
      if (step) begin
         mag_ff        <= mag_in;
         neg_ff        <= neg_in;
         first_ff      <= first_in;
         begin_ff      <= begin_in;
         held_x_ff     <= held_x_in;
         held_y_ff     <= held_y_in;
         held_begin_ff <= held_begin_in;
         held_end_ff   <= held_end_in;
      end
   end

endmodule

[hdl/phs_out_reg.sv]
// Result register between the scan engine and the result channel.
// Depends on phs_pkg.
`timescale 1ns / 1ps

module phs_out_reg
   import phs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load_valid,
   output logic       load_ready,
   input  result_type load_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff;
   result_type data_ff;

   // Free when empty or when the held result leaves this cycle
   assign load_ready = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_data   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_ready) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

endmodule

[hdl/position_hint_scanner.sv]
// Channel   Ports        Payload
// request   req_t*       tdata[7:0] = ch, tlast = last character of a comment
// response  rsp_t*       tdata = found, x, y, ints_begin, ints_end, too_long
//
// One character per cycle sustained while no last character waits for a full
// result register. A result goes from the input register, through one pass of
// the scan engine, into the result register, from which it is offered.
// Only a last character waits for the result register; other characters
// keep moving while a result is stalled on the response side.
// Synchronous active-high reset clears the scan state and both valid flags.
//
// Top level of the position hint scanner; depends on phs_pkg, phs_scan
// and phs_out_reg.
`timescale 1ns / 1ps

module position_hint_scanner
   import phs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata    // found, x, y, ints_begin, ints_end, too_long, pad
);

   logic       in_valid_ff;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;
   logic       advance;
   logic       load_ready;
   result_type scan_result;
   result_type out_result;

   // Character leaves the input register unless it is a last one and the
   // result register is full
   assign advance    = in_valid_ff && (!in_last_ff || load_ready);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   phs_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .ch     (in_ch_ff),
      .last   (in_last_ff),
      .result (scan_result)
   );

   phs_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (advance && in_last_ff),
      .load_ready (load_ready),
      .load_data  (scan_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_result)
   );

   // Response packing, first field in the lowest bit
   assign rsp_tdata = {5'b00000, out_result.too_long, out_result.ints_end,
                       out_result.ints_begin, out_result.y, out_result.x,
                       out_result.found};

endmodule

[hdl/phs_checker.sv]
// Port-level checks for the position hint scanner, bound to the top level.
// Depends on the port list of position_hint_scanner only.
`timescale 1ns / 1ps

module phs_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   // Nothing is offered and the input is free straight after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("response valid or request blocked after reset");

   // A stalled response holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // An overlong comment never reports a hint
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[90]))
      else $error("found and too_long both set");

   // No hint means all coordinate and span fields are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[89:1] == 89'd0)
      else $error("fields set without a hint");

   // A hint span is never empty: its end lies past its begin
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[89:77] > {1'b0, rsp_tdata[76:65]})
      else $error("hint span is empty");

endmodule

bind position_hint_scanner phs_port_checks u_port_checks (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/phs_checker.sv]
// Checker for the position hint scanner: follows both stream channels, predicts
// each comment's result from the accepted characters and compares field by field.
// Depends on phs_pkg for the scan modes, the result record and the widths.
`timescale 1ns / 1ps

module phs_checker
   import phs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   output int          fail_count,
   output int          outstanding
);

   // Bit positions of the result fields in rsp_tdata, found in bit 0
   localparam int X_LSB     = 1;
   localparam int Y_LSB     = 33;
   localparam int BEGIN_LSB = 65;
   localparam int END_LSB   = 77;
   localparam int LONG_BIT  = 90;

   // Predicted scanner state
   mode_type        scan_mode;
   logic [1:0]      mark_prog;
   logic [MAG_W-1:0] mag;
   logic            neg;
   logic [31:0]     first_val;
   int              char_count;
   int              begin_idx;
   logic            matched;
   result_type      held;

   // Results still owed by the block, oldest first
   result_type      hints_due[$];

   function automatic logic blank_char(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic sign_char(input logic [7:0] c);
      return c == CH_PLUS || c == CH_MINUS;
   endfunction

   function automatic void clear_scan();
      scan_mode  = MODE_SEARCH;
      mark_prog  = '0;
      mag        = '0;
      neg        = 1'b0;
      first_val  = '0;
      char_count = 0;
      begin_idx  = 0;
      matched    = 1'b0;
      held       = '0;
   endfunction

   // Marker matching; a stray '@' restarts the marker rather than dropping it
   function automatic void hunt_marker(input logic [7:0] c);
      logic [7:0] want;
      case (mark_prog)
         2'd0:    want = CH_AT;
         2'd1:    want = CH_P;
         2'd2:    want = CH_O;
         default: want = CH_S;
      endcase
      if (c == want) begin
         if (mark_prog == 2'd3) begin
            mark_prog = '0;
            scan_mode = MODE_NEED_SPACE;
         end else begin
            mark_prog = mark_prog + 2'd1;
         end
      end else begin
         mark_prog = (c == CH_AT) ? 2'd1 : 2'd0;
      end
   endfunction

   // Candidate broken: the offending character may itself open a new marker
   function automatic void drop_candidate(input logic [7:0] c);
      scan_mode = MODE_SEARCH;
      mark_prog = '0;
      hunt_marker(c);
   endfunction

   function automatic void open_number(input logic [7:0] c);
      neg = (c == CH_MINUS);
      mag = '0;
   endfunction

   // Returns 0 when the magnitude would exceed the 31-bit limit
   function automatic logic push_digit(input logic [7:0] c);
      logic [35:0] v;
      v = 36'(mag) * 36'd10 + 36'(c - CH_ZERO);
      if (v > 36'd2147483647) return 1'b0;
      mag = v[MAG_W-1:0];
      return 1'b1;
   endfunction

   function automatic logic [31:0] current_value();
      return neg ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
   endfunction

   function automatic void advance_scan(input logic [7:0] c, input int idx);
      case (scan_mode)
         MODE_SEARCH: hunt_marker(c);
         MODE_NEED_SPACE: begin
            if (blank_char(c)) scan_mode = MODE_SKIP1;
            else drop_candidate(c);
         end
         MODE_SKIP1: begin
            if (!blank_char(c)) begin
               begin_idx = idx;
               if (sign_char(c)) begin
                  open_number(c);
                  scan_mode = MODE_SIGN1;
               end else if (digit_char(c)) begin
                  open_number(c);
                  void'(push_digit(c));
                  scan_mode = MODE_DIG1;
               end else begin
                  drop_candidate(c);
               end
            end
         end
         MODE_SIGN1: begin
            if (digit_char(c)) begin
               void'(push_digit(c));
               scan_mode = MODE_DIG1;
            end else begin
               drop_candidate(c);
            end
         end
         MODE_DIG1: begin
            if (digit_char(c)) begin
               if (!push_digit(c)) drop_candidate(c);
            end else if (blank_char(c)) begin
               first_val = current_value();
               scan_mode = MODE_SKIP2;
            end else if (sign_char(c)) begin
               first_val = current_value();
               open_number(c);
               scan_mode = MODE_SIGN2;
            end else begin
               drop_candidate(c);
            end
         end
         MODE_SKIP2: begin
            if (!blank_char(c)) begin
               if (sign_char(c)) begin
                  open_number(c);
                  scan_mode = MODE_SIGN2;
               end else if (digit_char(c)) begin
                  open_number(c);
                  void'(push_digit(c));
                  scan_mode = MODE_DIG2;
               end else begin
                  drop_candidate(c);
               end
            end
         end
         MODE_SIGN2: begin
            if (digit_char(c)) begin
               void'(push_digit(c));
               scan_mode = MODE_DIG2;
            end else begin
               drop_candidate(c);
            end
         end
         MODE_DIG2: begin
            if (digit_char(c)) begin
               if (!push_digit(c)) drop_candidate(c);
            end else if (blank_char(c)) begin
               held.x          = first_val;
               held.y          = current_value();
               held.ints_begin = begin_idx[BEGIN_W-1:0];
               held.ints_end   = idx[END_W-1:0];
               matched         = 1'b1;
               scan_mode       = MODE_DONE;
            end else begin
               drop_candidate(c);
            end
         end
         default: ;
      endcase
   endfunction

   // One accepted character; the last one of a comment yields a result
   function automatic void take_char(input logic [7:0] c, input logic fin);
      int idx;
      logic over;
      result_type r;
      idx = char_count;
      if (char_count <= MAX_LEN) char_count++;
      over = char_count > MAX_LEN;
      if (!over && !matched) advance_scan(c, idx);
      if (fin) begin
         // comment ending inside the second integer still counts
         if (!over && !matched && scan_mode == MODE_DIG2) begin
            held.x          = first_val;
            held.y          = current_value();
            held.ints_begin = begin_idx[BEGIN_W-1:0];
            held.ints_end   = END_W'(idx + 1);
            matched         = 1'b1;
         end
         r = '0;
         if (over) begin
            r.too_long = 1'b1;
         end else if (matched) begin
            r = held;
            r.found = 1'b1;
            r.too_long = 1'b0;
         end
         hints_due = {hints_due, r};
         clear_scan();
      end
   endfunction

   function automatic void flag_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: mismatch on %s, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         clear_scan();
         hints_due.delete();
         outstanding <= 0;
      end else begin
         if (req_tvalid && req_tready) take_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.found      = rsp_tdata[0];
            got.x          = rsp_tdata[X_LSB +: 32];
            got.y          = rsp_tdata[Y_LSB +: 32];
            got.ints_begin = rsp_tdata[BEGIN_LSB +: BEGIN_W];
            got.ints_end   = rsp_tdata[END_LSB +: END_W];
            got.too_long   = rsp_tdata[LONG_BIT];
            if (hints_due.size() == 0) begin
               $display("%0t: unexpected result transfer, expected none, got %0h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = hints_due.pop_front();
               flag_field("found", 32'(want.found), 32'(got.found));
               flag_field("x", want.x, got.x);
               flag_field("y", want.y, got.y);
               flag_field("ints_begin", 32'(want.ints_begin), 32'(got.ints_begin));
               flag_field("ints_end", 32'(want.ints_end), 32'(got.ints_end));
               flag_field("too_long", 32'(want.too_long), 32'(got.too_long));
            end
         end
         outstanding <= hints_due.size();
      end
   end

endmodule

[tb/tb_top.sv]
// Testbench top for the position hint scanner: clock, reset, comment stimulus
// with random idling on both channels, watchdog and verdict.
// Depends on phs_pkg, position_hint_scanner and phs_checker.
`timescale 1ns / 1ps

module tb_top
   import phs_pkg::*;
();

   localparam int IDLE_LIMIT   = 500;
   localparam int RANDOM_CHARS = 100;
   localparam int QUIET_COUNT  = 4;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] ch
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;   // found, x, y, ints_begin, ints_end, too_long, pad
   int          fail_count;
   int          outstanding;

   // Stimulus control
   logic [7:0]  comment_buf[$];
   int          gap_pct;
   int          stall_pct;
   logic        quiet;
   int          stall_left;
   int          idle_cycles;
   int          sent_chars;
   string       noise_pool;

   position_hint_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   phs_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Response side back-pressure in random bursts
   initial rsp_tready <= 1'b0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic void add_byte(input logic [7:0] b);
      comment_buf = {comment_buf, b};
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void add_noise();
      if ($urandom_range(0, 1) == 1) add_byte(8'($urandom_range(0, 255)));
      else add_byte(noise_pool[$urandom_range(0, noise_pool.len() - 1)]);
   endfunction

   function automatic void add_blanks(input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endfunction

   // Optional sign, then digits from small values up past the overflow limit
   function automatic void add_number();
      int style;
      longint unsigned v;
      case ($urandom_range(0, 3))
         0: add_byte(CH_PLUS);
         1: add_byte(CH_MINUS);
         default: ;
      endcase
      style = $urandom_range(0, 9);
      if (style < 5) v = $urandom_range(0, 999);
      else if (style < 8) v = $urandom_range(0, 32'h7FFF_FFFF);
      else if (style == 8) v = 64'd2147483646 + $urandom_range(0, 3);
      else v = 64'd2147483648 + $urandom;
      if ($urandom_range(0, 7) == 0) add_text("00");
      add_text($sformatf("%0d", v));
   endfunction

   // Mostly well-formed hints with random content, the rest noise or broken
   function automatic void make_random_comment();
      comment_buf.delete();
      repeat ($urandom_range(0, 5)) add_noise();
      if ($urandom_range(0, 9) < 8) begin
         if ($urandom_range(0, 5) == 0) add_text("@po");
         add_text("@pos");
         add_blanks(($urandom_range(0, 9) == 0) ? 0 : 1, 3);
         add_number();
         add_blanks(0, 2);
         add_number();
         case ($urandom_range(0, 3))
            0: ;
            1: begin
               add_blanks(1, 2);
               repeat ($urandom_range(0, 4)) add_noise();
            end
            2: repeat ($urandom_range(1, 3)) add_noise();
            default: begin
               add_blanks(0, 1);
               add_text("@pos 1 -2");
            end
         endcase
      end else begin
         repeat ($urandom_range(1, 12)) add_noise();
      end
      if ($urandom_range(0, 5) == 0)
         comment_buf[$urandom_range(0, comment_buf.size() - 1)] = 8'($urandom_range(0, 255));
   endfunction

   // Sends comment_buf one character per transfer, last flagged by tlast
   task automatic send_comment();
      for (int i = 0; i < comment_buf.size(); i++) begin
         if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= comment_buf[i];
         req_tlast  <= (i == comment_buf.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      sent_chars += comment_buf.size();
   endtask

   task automatic send_text(input string s);
      comment_buf.delete();
      add_text(s);
      send_comment();
   endtask

   // Idling strength changes per comment so that calm stretches occur too
   task automatic pick_pace();
      case ($urandom_range(0, 2))
         0: begin gap_pct = 0;  stall_pct = 0;  end
         1: begin gap_pct = 15; stall_pct = 15; end
         default: begin gap_pct = 40; stall_pct = 35; end
      endcase
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      quiet       = 1'b0;
      gap_pct     = 20;
      stall_pct   = 20;
      stall_left  = 0;
      idle_cycles = 0;
      sent_chars  = 0;
      noise_pool  = "@pos +-\t0123456789ab";
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: well-formed hints, extremes and several ways a candidate breaks
      send_text("@pos 12 34");
      send_text("x @pos\t-5+7 tail");
      send_text("@pos +2147483647 -2147483647 ");
      send_text("@pos\t\t-2147483647\t\t+2147483647\tz");
      send_text("@pos 0000000000002147483647 -0");
      send_text("@pos 2147483648 1");
      send_text("@pos 1 21474836470 ");
      send_text("@@pos 1 2");
      send_text("@po@pos 3 4");
      send_text("@pos1 2");
      send_text("@pos 1 2x");
      send_text("@pos 1 2x@pos 5 6 ");
      send_text("@pos 7");
      send_text("@pos 7 -");
      send_text("@pos --1 2");
      send_text("@pos 1 2 @pos 3 4");
      send_text("@pos 0 0\t");
      send_text("@");
      send_text("5");
      comment_buf.delete();
      repeat (6) add_byte(8'($urandom_range(128, 255)));
      add_text("@pos 9 9");
      send_comment();

      // Random comments, then a final stretch without idling
      sent_chars = 0;
      while (sent_chars < RANDOM_CHARS) begin
         pick_pace();
         make_random_comment();
         send_comment();
      end
      quiet = 1'b1;
      repeat (QUIET_COUNT) begin
         make_random_comment();
         send_comment();
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      // Drain outstanding results, then allow for the pipeline latency
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
